>>> src/duplicate_frame_filter_unit_assert.svh
// Assertion macros for the duplicate frame filter RTL.
`ifndef DUPLICATE_FRAME_FILTER_UNIT_ASSERT_SVH
`define DUPLICATE_FRAME_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define DFF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("duplicate frame filter: implication check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define DFF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("duplicate frame filter: next-cycle check failed");

`endif

>>> src/dff_pkg.sv
// Types, constants and the CRC step function of the duplicate frame filter.
`timescale 1ns / 1ps
`default_nettype none
package dff_pkg;

	localparam int SLOTS = 8;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam logic [15:0] CRC_POLY = 16'h8408;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] HOLD_RESET = 16'd30;

	typedef enum logic [1:0] {
		ACT_RESTART = 2'd0,
		ACT_BYTE    = 2'd1,
		ACT_CHECK   = 2'd2,
		ACT_ADD     = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_SCAN  = 2'd1,
		ST_WRITE = 2'd2
	} state_t;

	typedef struct packed {
		logic [31:0] expiry;
		logic [15:0] crc;
	} slot_t;

	localparam int SLOT_BITS = $bits(slot_t);

	typedef struct packed {
		logic       restart;
		logic       fold;
		logic [7:0] data;
	} crc_cmd_t;

	// Reflected CRC-16 over one byte, least significant bit first.
	function automatic logic [15:0] crc_fold(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		logic        lsb;
		c = crc_in;
		for (int k = 0; k < 8; k++) begin
			lsb = c[0] ^ b[k];
			c = {1'b0, c[15:1]};
			if (lsb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

>>> src/dff_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module dff_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                                        clk,
	input  wire logic                                        we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                            wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> src/dff_crc.sv
// Running CRC-16 register with restart and byte fold.
`timescale 1ns / 1ps
`default_nettype none
module dff_crc (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dff_pkg::crc_cmd_t cmd,
	output logic [15:0]            crc
);
	import dff_pkg::*;

	logic [15:0] crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (cmd.restart) begin
			crc_q <= CRC_INIT;
		end else if (cmd.fold) begin
			crc_q <= crc_fold(crc_q, cmd.data);
		end
	end

	assign crc = crc_q;

endmodule
`default_nettype wire

>>> src/dff_ctrl.sv
// Request sequencer: scans the slot table for check and add, and forms results.
`timescale 1ns / 1ps
`default_nettype none
`include "duplicate_frame_filter_unit_assert.svh"
module dff_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire dff_pkg::act_t              action,
	input  wire logic [7:0]                 data_byte,
	input  wire logic [31:0]                now,
	input  wire logic [15:0]                hold_time,
	input  wire logic [15:0]                crc,
	output logic                            busy,
	output logic                            done,
	output logic                            is_duplicate,
	output logic [2:0]                      slot_written,
	output logic                            replaced_oldest,
	output dff_pkg::crc_cmd_t               crc_cmd,
	output logic                            ram_we,
	output logic [dff_pkg::SLOT_W-1:0]      ram_waddr,
	output dff_pkg::slot_t                  ram_wdata,
	output logic [dff_pkg::SLOT_W-1:0]      ram_raddr,
	input  wire dff_pkg::slot_t             ram_rdata
);
	import dff_pkg::*;

	state_t              state_q, state_d;
	act_t                act_q;
	logic [31:0]         now_q;
	logic [SLOT_W-1:0]   cnt_q;
	logic [SLOT_W-1:0]   target_q;
	logic [31:0]         oldest_q;
	logic                found_q;
	logic                dup_q;
	logic [SLOTS-1:0]    valid_q;
	logic                done_q;
	logic                dup_out_q;
	logic [2:0]          written_q;
	logic                evicted_q;

	logic                accept;
	logic                last;
	logic [31:0]         exp_eff;
	logic                expired;
	logic                hit;
	logic [31:0]         diff;

	assign accept  = start && (state_q == ST_IDLE);
	assign last    = (cnt_q == SLOT_W'(SLOTS - 1));
	// A slot that was never written since reset reads as empty.
	assign exp_eff = valid_q[cnt_q] ? ram_rdata.expiry : 32'd0;
	assign expired = now_q > exp_eff;
	assign hit     = (exp_eff != 32'd0) && !expired && (ram_rdata.crc == crc);
	assign diff    = exp_eff - oldest_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (action == ACT_CHECK || action == ACT_ADD)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last) begin
					state_d = (act_q == ACT_ADD) ? ST_WRITE : ST_IDLE;
				end
			end
			ST_WRITE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			valid_q   <= '0;
			found_q   <= 1'b0;
			dup_q     <= 1'b0;
			done_q    <= 1'b0;
			dup_out_q <= 1'b0;
			written_q <= 3'd0;
			evicted_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						act_q    <= action;
						now_q    <= now;
						cnt_q    <= '0;
						found_q  <= 1'b0;
						dup_q    <= 1'b0;
						target_q <= '0;
						if (action == ACT_RESTART || action == ACT_BYTE) begin
							done_q    <= 1'b1;
							dup_out_q <= 1'b0;
							written_q <= 3'd0;
							evicted_q <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + SLOT_W'(1);
					if (act_q == ACT_CHECK) begin
						if (expired) begin
							valid_q[cnt_q] <= 1'b0;
						end
						dup_q <= dup_q | hit;
						if (last) begin
							done_q    <= 1'b1;
							dup_out_q <= dup_q | hit;
							written_q <= 3'd0;
							evicted_q <= 1'b0;
						end
					end else if (!found_q) begin
						// The first empty slot wins; until one shows up, track the oldest.
						if (exp_eff == 32'd0) begin
							found_q  <= 1'b1;
							target_q <= cnt_q;
						end else if (cnt_q == '0 || diff[31]) begin
							target_q <= cnt_q;
							oldest_q <= exp_eff;
						end
					end
				end
				ST_WRITE: begin
					valid_q[target_q] <= 1'b1;
					done_q    <= 1'b1;
					dup_out_q <= 1'b0;
					written_q <= 3'(32'(target_q));
					evicted_q <= !found_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign busy            = (state_q != ST_IDLE);
	assign done            = done_q;
	assign is_duplicate    = dup_out_q;
	assign slot_written    = written_q;
	assign replaced_oldest = evicted_q;

	assign crc_cmd.restart = accept && (action == ACT_RESTART);
	assign crc_cmd.fold    = accept && (action == ACT_BYTE);
	assign crc_cmd.data    = data_byte;

	// The next slot is fetched while the current one is evaluated.
	assign ram_raddr        = (state_q == ST_IDLE) ? '0 : cnt_q + SLOT_W'(1);
	assign ram_we           = (state_q == ST_WRITE);
	assign ram_waddr        = target_q;
	assign ram_wdata.expiry = now_q + {16'd0, hold_time};
	assign ram_wdata.crc    = crc;

	`DFF_ASSERT_NEXT(a_accept_progress, clk, arst_n, accept, done || busy)
	`DFF_ASSERT_IMPL(a_done_idle, clk, arst_n, done, !busy)
	`DFF_ASSERT_NEXT(a_write_result, clk, arst_n, state_q == ST_WRITE, done && !busy)
	`DFF_ASSERT_IMPL(a_dup_no_evict, clk, arst_n, is_duplicate, !replaced_oldest && slot_written == 3'd0)

endmodule
`default_nettype wire

>>> src/duplicate_frame_filter_unit.sv
// Restart and payload-byte requests: result in the cycle after acceptance, one request per cycle.
// Check requests: one slot read per cycle from the table RAM, result registered after the last slot is scanned.
// Add requests: table scan followed by the write state, which writes the slot and registers the result.
// busy is high while a scan or write runs; the result strobe done lasts one cycle, never stalled.
// Reset clears the CRC to 0xFFFF, hold time to 30 and marks every slot empty at once.
`timescale 1ns / 1ps
`default_nettype none
module duplicate_frame_filter_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  data_byte,
	input  wire logic [31:0] now,
	output logic             done,
	output logic             is_duplicate,
	output logic [15:0]      checksum,
	output logic [2:0]       slot_written,
	output logic             replaced_oldest,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);
	import dff_pkg::*;

	logic [15:0]       hold_time_q;
	logic [15:0]       crc;
	crc_cmd_t          crc_cmd;
	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr;
	slot_t             ram_wdata;
	logic [SLOT_W-1:0] ram_raddr;
	slot_t             ram_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_time_q <= HOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			hold_time_q <= cfg_data;
		end
	end

	dff_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (crc_cmd),
		.crc    (crc)
	);

	dff_ram #(
		.WIDTH (SLOT_BITS),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	dff_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.action          (act_t'(action)),
		.data_byte       (data_byte),
		.now             (now),
		.hold_time       (hold_time_q),
		.crc             (crc),
		.busy            (busy),
		.done            (done),
		.is_duplicate    (is_duplicate),
		.slot_written    (slot_written),
		.replaced_oldest (replaced_oldest),
		.crc_cmd         (crc_cmd),
		.ram_we          (ram_we),
		.ram_waddr       (ram_waddr),
		.ram_wdata       (ram_wdata),
		.ram_raddr       (ram_raddr),
		.ram_rdata       (ram_rdata)
	);

	// The CRC register holds still through the result cycle of every request.
	assign checksum = crc;

endmodule
`default_nettype wire

>>> tb/tb_duplicate_frame_filter_unit.sv
// Self-checking testbench for the duplicate frame filter: CRC folding, duplicate checks, table replacement.
`timescale 1ns / 1ps
module tb_duplicate_frame_filter_unit;
	import dff_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int FRAME_POOL = 6;
	localparam int FRAME_MAX = 8;

	typedef struct packed {
		logic        dup;
		logic [15:0] crc;
		logic [2:0]  slot;
		logic        evicted;
	} verdict_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  action;
	logic [7:0]  data_byte;
	logic [31:0] now;
	logic        done;
	logic        is_duplicate;
	logic [15:0] checksum;
	logic [2:0]  slot_written;
	logic        replaced_oldest;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	// Shadow copy of the filter state, updated as each request is accepted.
	logic [15:0] shadow_crc;
	logic [15:0] shadow_hold;
	logic [31:0] shadow_expiry [SLOTS];
	logic [15:0] shadow_sum [SLOTS];

	verdict_t    pending_verdicts[$];
	logic [31:0] wall_clock;
	int          idle_pct;
	int          mismatches;
	int          cycle_count;
	int          n_items;
	int          n_checks;
	int          n_dups;
	int          n_adds;
	int          n_evicts;
	int          n_hold_writes;

	duplicate_frame_filter_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.action         (action),
		.data_byte      (data_byte),
		.now            (now),
		.done           (done),
		.is_duplicate   (is_duplicate),
		.checksum       (checksum),
		.slot_written   (slot_written),
		.replaced_oldest(replaced_oldest),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c;
		for (int k = 0; k < 8; k++) begin
			if (r[0] ^ b[k]) begin
				r = (r >> 1) ^ CRC_POLY;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

	task automatic judge_item(input act_t act, input logic [7:0] b, input logic [31:0] t,
			output verdict_t v);
		logic [31:0] stamp;
		logic [31:0] oldest;
		logic [31:0] diff;
		int          target;
		bit          found;
		v = '0;
		case (act)
		ACT_RESTART: begin
			shadow_crc = CRC_INIT;
		end
		ACT_BYTE: begin
			shadow_crc = crc_step(shadow_crc, b);
		end
		ACT_CHECK: begin
			n_checks++;
			for (int i = 0; i < SLOTS; i++) begin
				if (t > shadow_expiry[i]) begin
					shadow_expiry[i] = '0;
				end
				if (shadow_expiry[i] != 0 && shadow_sum[i] == shadow_crc) begin
					v.dup = 1'b1;
				end
			end
			if (v.dup) begin
				n_dups++;
			end
		end
		default: begin
			n_adds++;
			stamp = t + {16'd0, shadow_hold};
			found = 1'b0;
			target = 0;
			for (int i = 0; i < SLOTS; i++) begin
				if (!found && shadow_expiry[i] == 0) begin
					target = i;
					found = 1'b1;
				end
			end
			// A full table gives up the slot whose expiry is oldest in wrapping time.
			if (!found) begin
				oldest = shadow_expiry[0];
				for (int i = 1; i < SLOTS; i++) begin
					diff = shadow_expiry[i] - oldest;
					if (diff[31]) begin
						target = i;
						oldest = shadow_expiry[i];
					end
				end
				v.evicted = 1'b1;
				n_evicts++;
			end
			shadow_expiry[target] = stamp;
			shadow_sum[target] = shadow_crc;
			v.slot = target[2:0];
		end
		endcase
		v.crc = shadow_crc;
	endtask

	task automatic send_item(input act_t act, input logic [7:0] b, input logic [31:0] t);
		verdict_t v;
		start <= 1'b1;
		action <= act;
		data_byte <= b;
		now <= t;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		judge_item(act, b, t, v);
		pending_verdicts.push_back(v);
		n_items++;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_verdicts.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_hold(input logic [15:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		shadow_hold = value;
		n_hold_writes++;
	endtask

	// Mostly well-formed packets drawn from a small pool so duplicates recur,
	// mixed with missing restarts, truncated frames and random noise requests.
	task automatic run_frames(input int packets);
		logic [7:0] pool [FRAME_POOL][FRAME_MAX];
		int         pool_len [FRAME_POOL];
		int         pick;
		int         roll;
		int         len;
		for (int f = 0; f < FRAME_POOL; f++) begin
			pool_len[f] = $urandom_range(1, FRAME_MAX);
			for (int j = 0; j < FRAME_MAX; j++) begin
				pool[f][j] = 8'($urandom);
			end
		end
		for (int p = 0; p < packets; p++) begin
			pick = $urandom_range(FRAME_POOL - 1);
			roll = $urandom_range(99);
			if (roll < 5) begin
				wall_clock = $urandom;
			end else begin
				wall_clock += $urandom_range(0, shadow_hold / 8 + 1);
			end
			if (roll < 10) begin
				repeat ($urandom_range(1, 3)) begin
					send_item(act_t'($urandom_range(3)), 8'($urandom), $urandom);
				end
			end else begin
				if (roll >= 15) begin
					send_item(ACT_RESTART, 8'($urandom), wall_clock);
				end
				len = (roll < 20) ? $urandom_range(1, pool_len[pick]) : pool_len[pick];
				for (int j = 0; j < len; j++) begin
					send_item(ACT_BYTE, pool[pick][j], wall_clock);
				end
				if (roll % 5 != 0) begin
					send_item(ACT_CHECK, 8'($urandom), wall_clock);
				end
				if (roll % 4 != 0) begin
					send_item(ACT_ADD, 8'($urandom), wall_clock);
				end
			end
		end
	endtask

	task automatic test_reset_state();
		idle_pct = 0;
		send_item(ACT_RESTART, 8'h00, 32'd0);
		send_item(ACT_BYTE, 8'h00, 32'd0);
		send_item(ACT_BYTE, 8'hFF, 32'd1);
		send_item(ACT_CHECK, 8'h00, 32'd5);
		send_item(ACT_ADD, 8'h00, 32'd5);
		// Expiry equal to the current time still counts as live.
		send_item(ACT_CHECK, 8'h00, 32'd35);
		send_item(ACT_CHECK, 8'h00, 32'd36);
	endtask

	task automatic test_table_fill();
		logic [31:0] stamps [SLOTS];
		stamps = '{32'd100, 32'hFFFF_FFF0, 32'h8000_0000, 32'h7FFF_FFF0,
			32'd200, 32'hFFFF_FF00, 32'd50, 32'h4000_0000};
		// Expiry wraps to zero, so the slot still reads as empty.
		send_item(ACT_ADD, 8'h00, 32'hFFFF_FFE2);
		for (int i = 0; i < SLOTS; i++) begin
			send_item(ACT_ADD, 8'h00, stamps[i]);
		end
		send_item(ACT_ADD, 8'h00, 32'd300);
		send_item(ACT_CHECK, 8'h00, 32'hFFFF_FFFF);
		send_item(ACT_CHECK, 8'h00, 32'd0);
	endtask

	task automatic test_hold_extremes();
		write_hold(16'd0);
		send_item(ACT_ADD, 8'h00, 32'd1000);
		send_item(ACT_CHECK, 8'h00, 32'd1000);
		send_item(ACT_CHECK, 8'h00, 32'd1001);
		write_hold(16'hFFFF);
		send_item(ACT_ADD, 8'h00, 32'hFFFF_0001);
		write_hold(16'd1);
		send_item(ACT_ADD, 8'h00, 32'd2000);
		send_item(ACT_CHECK, 8'h00, 32'd2001);
	endtask

	task automatic test_sparse_sender();
		write_hold(16'hFFFF);
		idle_pct = 20;
		wall_clock = $urandom;
		run_frames(36);
	endtask

	task automatic test_busy_sender();
		write_hold(16'd1);
		idle_pct = 75;
		run_frames(32);
	endtask

	task automatic test_back_to_back();
		write_hold(16'($urandom_range(2, 65534)));
		idle_pct = 0;
		run_frames(24);
		// Hold off the next request until the block has returned everything.
		drain_results();
		run_frames(8);
		write_hold(16'd0);
		run_frames(12);
		write_hold(HOLD_RESET);
		run_frames(8);
	endtask

	always @(posedge clk) begin : check_results
		verdict_t want;
		if (arst_n && done) begin
			if (pending_verdicts.size() == 0) begin
				$error("result with no request outstanding, checksum %h", checksum);
				mismatches++;
			end else begin
				want = pending_verdicts.pop_front();
				if (is_duplicate !== want.dup) begin
					$error("is_duplicate: expected %0b, got %0b", want.dup, is_duplicate);
					mismatches++;
				end
				if (checksum !== want.crc) begin
					$error("checksum: expected %h, got %h", want.crc, checksum);
					mismatches++;
				end
				if (slot_written !== want.slot) begin
					$error("slot_written: expected %0d, got %0d", want.slot, slot_written);
					mismatches++;
				end
				if (replaced_oldest !== want.evicted) begin
					$error("replaced_oldest: expected %0b, got %0b", want.evicted,
						replaced_oldest);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL duplicate_frame_filter_unit");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_RESTART;
		data_byte = 8'h00;
		now = 32'd0;
		cfg_valid = 1'b0;
		cfg_data = 16'd0;
		shadow_crc = CRC_INIT;
		shadow_hold = HOLD_RESET;
		for (int i = 0; i < SLOTS; i++) begin
			shadow_expiry[i] = '0;
			shadow_sum[i] = '0;
		end
		wall_clock = '0;
		idle_pct = 0;
		mismatches = 0;
		cycle_count = 0;
		n_items = 0;
		n_checks = 0;
		n_dups = 0;
		n_adds = 0;
		n_evicts = 0;
		n_hold_writes = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_table_fill();
		test_hold_extremes();
		test_sparse_sender();
		test_busy_sender();
		test_back_to_back();

		drain_results();
		repeat (SLOTS + 4) @(posedge clk);
		$display("Ran %0d requests: %0d checks (%0d duplicates), %0d adds (%0d evictions).",
			n_items, n_checks, n_dups, n_adds, n_evicts);
		$display("Hold time rewritten %0d times, including 0, 1 and 65535.", n_hold_writes);
		if (mismatches == 0 && pending_verdicts.size() == 0) begin
			$display("PASS duplicate_frame_filter_unit");
		end else begin
			$display("FAIL duplicate_frame_filter_unit");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+src
src/dff_pkg.sv
src/dff_ram.sv
src/dff_crc.sv
src/dff_ctrl.sv
src/duplicate_frame_filter_unit.sv
tb/tb_duplicate_frame_filter_unit.sv
